// ===== hdl/mcu_pkg.sv =====
// Package with operation codes, branch conditions and flag helpers for the ALU unit.
`timescale 1ns / 1ps
package mcu_pkg;
    localparam int WordWidth = 16;
    localparam int CmdWidth  = 5;
    localparam int FlagWidth = 4;
    localparam int CondWidth = 4;

    typedef enum logic [CmdWidth-1:0] {
        CMD_MOV = 5'd0, CMD_CMP = 5'd1, CMD_BIT = 5'd2, CMD_BIC = 5'd3, CMD_BIS = 5'd4,
        CMD_ADD = 5'd5, CMD_SUB = 5'd6, CMD_CLR = 5'd7, CMD_COM = 5'd8, CMD_INC = 5'd9,
        CMD_DEC = 5'd10, CMD_NEG = 5'd11, CMD_ADC = 5'd12, CMD_SBC = 5'd13,
        CMD_TST = 5'd14, CMD_ROR = 5'd15, CMD_ROL = 5'd16, CMD_ASR = 5'd17,
        CMD_ASL = 5'd18, CMD_SWAB = 5'd19, CMD_MUL = 5'd20, CMD_DIV = 5'd21,
        CMD_ASH = 5'd22, CMD_ASHC = 5'd23, CMD_CCLR = 5'd24, CMD_CSET = 5'd25,
        CMD_BR = 5'd26
    } cmd_t;

    typedef enum logic [CondWidth-1:0] {
        BC_AL = 4'd0, BC_EQ = 4'd1, BC_NE = 4'd2, BC_MI = 4'd3, BC_PL = 4'd4,
        BC_CS = 4'd5, BC_CC = 4'd6, BC_VS = 4'd7, BC_VC = 4'd8, BC_GE = 4'd9,
        BC_LT = 4'd10, BC_GT = 4'd11, BC_LE = 4'd12, BC_HI = 4'd13, BC_LOS = 4'd14
    } cond_t;

    localparam logic [15:0] HighByteMask = 16'hff00;
    localparam logic [15:0] LowByteMask  = 16'h00ff;

    function automatic logic branch_test(input logic [3:0] cond, input logic [3:0] f);
        logic n;
        logic z;
        logic v;
        logic c;
        n = f[3];
        z = f[2];
        v = f[1];
        c = f[0];
        case (cond)
            BC_AL:   branch_test = 1'b1;
            BC_EQ:   branch_test = z;
            BC_NE:   branch_test = !z;
            BC_MI:   branch_test = n;
            BC_PL:   branch_test = !n;
            BC_CS:   branch_test = c;
            BC_CC:   branch_test = !c;
            BC_VS:   branch_test = v;
            BC_VC:   branch_test = !v;
            BC_GE:   branch_test = (n == v);
            BC_LT:   branch_test = (n != v);
            BC_GT:   branch_test = !z && (n == v);
            BC_LE:   branch_test = z || (n != v);
            BC_HI:   branch_test = !c && !z;
            BC_LOS:  branch_test = c || z;
            default: branch_test = 1'b0;
        endcase
    endfunction
endpackage

// ===== hdl/minicomputer_alu_condition_codes_unit.sv =====
// Top level of the minicomputer execute unit with N Z V C condition codes.
//
//   channel | dir | handshake            | payload
//   s_axis  | in  | s_tvalid / s_tready  | s_tdata: one operation request
//   m_axis  | out | m_tvalid / m_tready  | m_tdata: one result request
//
// m_tvalid rises after acceptance once the request has gone through its steps: ALU, flag and
// branch requests go straight to the output step, a divide by zero through fix-up first.
// Multiply runs 16 shift-add steps, fix-up, output; divide 32 restoring steps, fix-up, output;
// ash/ashc one shift step per unit of shift count (32 for a count of -32), a final shift-state
// check, fix-up, output. The block takes one request at a time; s_tready is high only while no
// request is in work and the output register is free or being taken. Reset clears the flags to zero and drops m_tvalid.
`timescale 1ns / 1ps
module minicomputer_alu_condition_codes_unit
    import mcu_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // s_tdata fields from bit 0: command[4:0], byte_mode[5], source_word[21:6],
    // dest_word[37:22], pair_word[53:38], dest_is_odd[54], dest_is_register[55],
    // flag_mask[59:56], branch_condition[63:60]
    input  logic [63:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // m_tdata fields from bit 0: result_word[15:0], pair_result[31:16],
    // write_result[32], write_pair[33], new_flags[37:34], branch_taken[38], zero fill
    output logic [39:0] m_tdata
);
    typedef enum logic [2:0] { ST_IDLE, ST_SHIFT, ST_MUL, ST_DIV, ST_FIX, ST_OUT } state_t;

    state_t state_reg;
    logic [3:0]  flags_reg;
    logic [4:0]  cmd_reg;
    logic        odd_reg;
    logic [15:0] s_reg;
    logic [31:0] acc_reg;     // shift value / shifted multiplicand / dividend-quotient
    logic [15:0] mq_reg;      // multiplier or divisor magnitude
    logic [5:0]  cnt_reg;
    logic        left_reg, sc_reg, sv_reg, neg_reg, rneg_reg;
    logic [32:0] prod_reg;
    logic [15:0] res_reg, pres_reg;
    logic        wr_reg, wp_reg, bt_reg, mval_reg;
    logic [3:0]  nf_reg;

    logic [4:0]  i_cmd;
    logic        i_bm, i_odd, i_isreg;
    logic [15:0] i_s, i_d, i_p;
    logic [3:0]  i_mask, i_bc;
    assign i_cmd   = s_tdata[4:0];
    assign i_bm    = s_tdata[5];
    assign i_s     = s_tdata[21:6];
    assign i_d     = s_tdata[37:22];
    assign i_p     = s_tdata[53:38];
    assign i_odd   = s_tdata[54];
    assign i_isreg = s_tdata[55];
    assign i_mask  = s_tdata[59:56];
    assign i_bc    = s_tdata[63:60];

    logic accept;
    assign s_tready = (state_reg == ST_IDLE) && (!mval_reg || m_tready);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = mval_reg;
    assign m_tdata  = {1'b0, bt_reg, nf_reg, wp_reg, wr_reg, pres_reg, res_reg};

    // Simple operations, computed combinationally: word and byte ALU group, swab, flag ops, branch.
    logic        byt;
    logic [15:0] m, sb, ds, ss, r, sres;
    logic [16:0] t;
    logic        n, z, v, c, wr, bt, simple;
    always_comb
    begin
        byt = i_bm && (i_cmd <= 5'd18) && (i_cmd != CMD_ADD) && (i_cmd != CMD_SUB);
        m   = byt ? LowByteMask : 16'hffff;
        sb  = byt ? 16'h0080 : 16'h8000;
        ds  = i_d & m;
        ss  = i_s & m;
        n = flags_reg[3];
        z = flags_reg[2];
        v = flags_reg[1];
        c = flags_reg[0];
        r = 16'd0;
        t = 17'd0;
        wr = 1'b0;
        bt = 1'b0;
        sres = i_d;
        simple = 1'b1;
        case (i_cmd)
            CMD_MOV: begin r = ss; v = 1'b0; wr = 1'b1; end
            CMD_CMP:
            begin
                r = (ss - ds) & m;
                v = (|((ss ^ ds) & sb)) && (|((ss ^ r) & sb));
                c = ss < ds;
            end
            CMD_BIT: begin r = ds & ss; v = 1'b0; end
            CMD_BIC: begin r = ds & ~ss & m; v = 1'b0; wr = 1'b1; end
            CMD_BIS: begin r = ds | ss; v = 1'b0; wr = 1'b1; end
            CMD_ADD:
            begin
                t = {1'b0, ds} + {1'b0, ss};
                r = t[15:0];
                v = !(|((ss ^ ds) & sb)) && (|((ss ^ r) & sb));
                c = t[16];
                wr = 1'b1;
            end
            CMD_SUB:
            begin
                r = ds - ss;
                v = (|((ss ^ ds) & sb)) && !(|((ss ^ r) & sb));
                c = ds < ss;
                wr = 1'b1;
            end
            CMD_CLR: begin r = 16'd0; v = 1'b0; c = 1'b0; wr = 1'b1; end
            CMD_COM: begin r = ~ds & m; v = 1'b0; c = 1'b1; wr = 1'b1; end
            CMD_INC: begin r = (ds + 16'd1) & m; v = ds == sb - 16'd1; wr = 1'b1; end
            CMD_DEC: begin r = (ds - 16'd1) & m; v = ds == sb; wr = 1'b1; end
            CMD_NEG:
            begin
                r = (16'd0 - ds) & m;
                v = r == sb;
                c = r != 16'd0;
                wr = 1'b1;
            end
            CMD_ADC:
            begin
                r = (ds + {15'd0, c}) & m;
                v = c && (ds == sb - 16'd1);
                c = c && (ds == m);
                wr = 1'b1;
            end
            CMD_SBC:
            begin
                r = (ds - {15'd0, c}) & m;
                v = c && (ds == sb);
                c = c && (ds == 16'd0);
                wr = 1'b1;
            end
            CMD_TST: begin r = ds; v = 1'b0; c = 1'b0; end
            CMD_ROR:
            begin
                r = (ds >> 1) | (c ? sb : 16'd0);
                c = ds[0];
                wr = 1'b1;
            end
            CMD_ROL:
            begin
                r = ((ds << 1) | {15'd0, c}) & m;
                c = |(ds & sb);
                wr = 1'b1;
            end
            CMD_ASR: begin r = (ds >> 1) | (ds & sb); c = ds[0]; wr = 1'b1; end
            CMD_ASL: begin r = (ds << 1) & m; c = |(ds & sb); wr = 1'b1; end
            CMD_SWAB:
            begin
                sres = {i_d[7:0], i_d[15:8]};
                n = sres[7];
                z = sres[7:0] == 8'd0;
                v = 1'b0;
                c = 1'b0;
                wr = 1'b1;
            end
            CMD_MUL, CMD_DIV, CMD_ASH, CMD_ASHC: simple = 1'b0;
            CMD_CCLR:
            begin
                n = n & ~i_mask[3];
                z = z & ~i_mask[2];
                v = v & ~i_mask[1];
                c = c & ~i_mask[0];
            end
            CMD_CSET:
            begin
                n = n | i_mask[3];
                z = z | i_mask[2];
                v = v | i_mask[1];
                c = c | i_mask[0];
            end
            CMD_BR: bt = branch_test(i_bc, flags_reg);
            default: ;
        endcase
        if (i_cmd <= 5'd18)
        begin
            n = |(r & sb);
            z = (r & m) == 16'd0;
            if (i_cmd >= 5'd15)
                v = n != c;
            if (wr)
            begin
                if ((i_cmd == CMD_MOV) && byt && i_isreg)
                    sres = {{8{r[7]}}, r[7:0]};
                else if (byt)
                    sres = (i_d & HighByteMask) | r;
                else
                    sres = r;
            end
        end
    end

    // Magnitudes for mul and div and the restoring divide step.
    logic [15:0] s_abs, d_abs;
    logic [31:0] dv_in, dv_abs;
    logic [16:0] trial;
    logic [5:0]  shcnt;
    assign s_abs  = i_s[15] ? (16'd0 - i_s) : i_s;
    assign d_abs  = i_d[15] ? (16'd0 - i_d) : i_d;
    assign dv_in  = i_odd ? {i_p, i_d} : {i_d, i_p};
    assign dv_abs = dv_in[31] ? (32'd0 - dv_in) : dv_in;
    assign shcnt  = i_s[5:0];
    // acc holds the remaining dividend bits with quotient bits shifted in; prod_reg[32:16] is the partial remainder.
    assign trial  = {prod_reg[31:16], acc_reg[31]} - {1'b0, mq_reg};

    // Shared shifter step for ash and ashc.
    logic        wide;
    logic [31:0] sh_x;
    logic        sh_top, sh_newtop;
    always_comb
    begin
        wide   = cmd_reg == CMD_ASHC;
        sh_top = wide ? acc_reg[31] : acc_reg[15];
        if (left_reg)
            sh_x = wide ? {acc_reg[30:0], 1'b0} : {16'd0, acc_reg[14:0], 1'b0};
        else
            sh_x = wide ? {acc_reg[31], acc_reg[31:1]} : {16'd0, acc_reg[15], acc_reg[15:1]};
        sh_newtop = wide ? sh_x[31] : sh_x[15];
    end

    // Final values of the multi-cycle operations.
    logic [31:0] pr, q, rm;
    always_comb
    begin
        pr = neg_reg ? (32'd0 - prod_reg[31:0]) : prod_reg[31:0];
        q  = neg_reg ? (32'd0 - {16'd0, acc_reg[15:0]}) : {16'd0, acc_reg[15:0]};
        rm = rneg_reg ? (32'd0 - {16'd0, prod_reg[31:16]}) : {16'd0, prod_reg[31:16]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            flags_reg <= 4'd0;
            mval_reg  <= 1'b0;
        end
        else
        begin
            if (mval_reg && m_tready)
                mval_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        cmd_reg <= i_cmd;
                        odd_reg <= i_odd;
                        s_reg <= i_s;
                        wr_reg <= simple && wr;
                        wp_reg <= 1'b0;
                        bt_reg <= simple && bt;
                        res_reg <= simple ? sres : i_d;
                        pres_reg <= i_p;
                        sc_reg <= 1'b0;
                        sv_reg <= 1'b0;
                        if (simple)
                        begin
                            nf_reg <= {n, z, v, c};
                            flags_reg <= {n, z, v, c};
                            state_reg <= ST_OUT;
                        end
                        else if (i_cmd == CMD_MUL)
                        begin
                            acc_reg <= {16'd0, d_abs};
                            mq_reg <= s_abs;
                            prod_reg <= 33'd0;
                            neg_reg <= i_d[15] ^ i_s[15];
                            cnt_reg <= 6'd16;
                            state_reg <= ST_MUL;
                        end
                        else if (i_cmd == CMD_DIV)
                        begin
                            acc_reg <= dv_abs;
                            mq_reg <= s_abs;
                            prod_reg <= 33'd0;
                            neg_reg <= dv_in[31] ^ i_s[15];
                            rneg_reg <= dv_in[31];
                            cnt_reg <= 6'd32;
                            state_reg <= (i_s == 16'd0) ? ST_FIX : ST_DIV;
                        end
                        else
                        begin
                            if (i_cmd == CMD_ASHC)
                                acc_reg <= i_odd ? {i_d, i_d} : {i_d, i_p};
                            else
                                acc_reg <= {16'd0, i_d};
                            left_reg <= !shcnt[5];
                            cnt_reg <= shcnt[5] ? (6'd0 - shcnt) : shcnt;
                            state_reg <= ST_SHIFT;
                        end
                    end
                end
                ST_SHIFT:
                begin
                    if (cnt_reg == 6'd0)
                        state_reg <= ST_FIX;
                    else
                    begin
                        acc_reg <= sh_x;
                        sc_reg <= left_reg ? sh_top : acc_reg[0];
                        if (sh_newtop != sh_top)
                            sv_reg <= 1'b1;
                        cnt_reg <= cnt_reg - 6'd1;
                    end
                end
                ST_MUL:
                begin
                    // Shift-add over the multiplier bits, LSB first.
                    if (mq_reg[0])
                        prod_reg <= prod_reg + {1'b0, acc_reg};
                    acc_reg <= {acc_reg[30:0], 1'b0};
                    mq_reg <= {1'b0, mq_reg[15:1]};
                    cnt_reg <= cnt_reg - 6'd1;
                    if (cnt_reg == 6'd1)
                        state_reg <= ST_FIX;
                end
                ST_DIV:
                begin
                    // Restoring step: partial remainder in prod_reg[32:16].
                    if (!trial[16])
                        prod_reg[32:16] <= trial;
                    else
                        prod_reg[32:16] <= {prod_reg[31:16], acc_reg[31]};
                    acc_reg <= {acc_reg[30:0], !trial[16]};
                    cnt_reg <= cnt_reg - 6'd1;
                    if (cnt_reg == 6'd1)
                        state_reg <= ST_FIX;
                end
                ST_FIX:
                begin
                    state_reg <= ST_OUT;
                    case (cmd_reg)
                        CMD_MUL:
                        begin
                            wr_reg <= 1'b1;
                            nf_reg <= {pr[31], pr == 32'd0, 1'b0,
                                       pr[31:15] != {17{pr[15]}}};
                            flags_reg <= {pr[31], pr == 32'd0, 1'b0,
                                          pr[31:15] != {17{pr[15]}}};
                            if (odd_reg)
                                res_reg <= pr[15:0];
                            else
                            begin
                                res_reg <= pr[31:16];
                                pres_reg <= pr[15:0];
                                wp_reg <= 1'b1;
                            end
                        end
                        CMD_DIV:
                        begin
                            if (s_reg == 16'd0)
                            begin
                                nf_reg <= 4'b0111;
                                flags_reg <= 4'b0111;
                            end
                            else if ((acc_reg[31:16] != 16'd0) ||
                                     (q[15:0] != 16'd0 && q[15] != neg_reg))
                            begin
                                nf_reg <= 4'b0010;
                                flags_reg <= 4'b0010;
                            end
                            else
                            begin
                                nf_reg <= {q[15], q[15:0] == 16'd0, 2'b00};
                                flags_reg <= {q[15], q[15:0] == 16'd0, 2'b00};
                                wr_reg <= 1'b1;
                                wp_reg <= 1'b1;
                                if (odd_reg)
                                begin
                                    pres_reg <= q[15:0];
                                    res_reg <= rm[15:0];
                                end
                                else
                                begin
                                    res_reg <= q[15:0];
                                    pres_reg <= rm[15:0];
                                end
                            end
                        end
                        CMD_ASH:
                        begin
                            wr_reg <= 1'b1;
                            res_reg <= acc_reg[15:0];
                            nf_reg <= {acc_reg[15], acc_reg[15:0] == 16'd0, sv_reg, sc_reg};
                            flags_reg <= {acc_reg[15], acc_reg[15:0] == 16'd0,
                                          sv_reg, sc_reg};
                        end
                        default:
                        begin
                            wr_reg <= 1'b1;
                            nf_reg <= {acc_reg[31], acc_reg == 32'd0, sv_reg, sc_reg};
                            flags_reg <= {acc_reg[31], acc_reg == 32'd0, sv_reg, sc_reg};
                            if (odd_reg)
                                res_reg <= acc_reg[15:0];
                            else
                            begin
                                res_reg <= acc_reg[31:16];
                                pres_reg <= acc_reg[15:0];
                                wp_reg <= 1'b1;
                            end
                        end
                    endcase
                end
                ST_OUT:
                begin
                    mval_reg <= 1'b1;
                    state_reg <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    // No new request may be taken while one is still in work.
    a_busy_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !s_tready) else $error("accept while busy");
    // A result is only raised from the output step.
    a_out_from_step: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(state_reg) == ST_OUT) else $error("stray result");
    // Flags change only after a request finishes its work.
    a_flags_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MUL || state_reg == ST_DIV || state_reg == ST_SHIFT)
        |=> $stable(flags_reg)) else $error("flags changed mid operation");
`endif
endmodule

// ===== verif/minicomputer_alu_condition_codes_unit_tb.sv =====
// Self-checking testbench for the minicomputer execute unit with N Z V C condition codes.
`timescale 1ns / 1ps
module minicomputer_alu_condition_codes_unit_tb;
    import mcu_pkg::*;

    // Operation request fields as the block sees them in s_tdata.
    typedef struct packed {
        logic [3:0]  cond;
        logic [3:0]  fmask;
        logic        is_reg;
        logic        is_odd;
        logic [15:0] pair;
        logic [15:0] dst;
        logic [15:0] src;
        logic        byte_op;
        logic [4:0]  cmd;
    } op_req_t;

    // Result request fields as they come back in m_tdata.
    typedef struct packed {
        logic        taken;
        logic [3:0]  flags;
        logic        wr_pair;
        logic        wr_res;
        logic [15:0] pair_res;
        logic [15:0] res;
    } alu_res_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;

    minicomputer_alu_condition_codes_unit u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // The predictor keeps its own copy of the flags, updated per accepted request.
    logic [3:0] model_flags;
    alu_res_t   expected_results[$];
    int         mismatch_count = 0;
    int         result_count = 0;
    int         request_count;
    int         idle_cycles = 0;

    // Idle controls: percentage of cycles each side holds off.
    int         send_idle_pct;
    int         recv_stall_pct;
    bit         recv_hold;

    localparam int WatchdogLimit = 20000;

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // Arithmetic shift used by ash and ashc; returns value, sets carry and overflow.
    function automatic logic [31:0] shift_arith(input logic [31:0] x, input int width,
                                               input logic [5:0] cnt,
                                               output logic cy, output logic ov);
        logic [31:0] top;
        logic [31:0] msk;
        logic        was_neg;
        int          steps;
        bit          left;
        top  = 32'h1 << (width - 1);
        msk  = (width == 32) ? 32'hffff_ffff : 32'h0000_ffff;
        left = !cnt[5];
        steps = left ? int'(cnt) : 64 - int'(cnt);
        cy = 1'b0;
        ov = 1'b0;
        for (int i = 0; i < steps; i++)
        begin
            was_neg = (x & top) != 0;
            if (left)
            begin
                cy = was_neg;
                x  = (x << 1) & msk;
            end
            else
            begin
                cy = x[0];
                x  = (x >> 1) | (x & top);
            end
            if (((x & top) != 0) != was_neg)
                ov = 1'b1;
        end
        return x;
    endfunction

    // Computes the expected result of one request and advances the flag copy.
    function automatic alu_res_t execute_op(input op_req_t rq);
        alu_res_t    o;
        logic        n, z, v, c, bt, wr, wp, bytef;
        logic [15:0] m, sb, ds, ss, r, res, pres;
        logic [16:0] t;
        logic [31:0] x;
        int          prod;
        longint      dv, dvs, q, rm;
        n = model_flags[3];
        z = model_flags[2];
        v = model_flags[1];
        c = model_flags[0];
        bytef = rq.byte_op && rq.cmd <= CMD_ASL && rq.cmd != CMD_ADD && rq.cmd != CMD_SUB;
        m  = bytef ? 16'h00ff : 16'hffff;
        sb = bytef ? 16'h0080 : 16'h8000;
        ds = rq.dst & m;
        ss = rq.src & m;
        r = '0;
        res = rq.dst;
        pres = rq.pair;
        wr = 0;
        wp = 0;
        bt = 0;
        case (rq.cmd)
            CMD_MOV: begin r = ss; v = 0; wr = 1; end
            CMD_CMP:
            begin
                r = (ss - ds) & m;
                v = ((ss ^ ds) & sb) != 0 && ((ss ^ r) & sb) != 0;
                c = ss < ds;
            end
            CMD_BIT: begin r = ds & ss; v = 0; end
            CMD_BIC: begin r = ds & ~ss & m; v = 0; wr = 1; end
            CMD_BIS: begin r = ds | ss; v = 0; wr = 1; end
            CMD_ADD:
            begin
                t = {1'b0, ds} + {1'b0, ss};
                r = t[15:0] & m;
                v = ((ss ^ ds) & sb) == 0 && ((ss ^ r) & sb) != 0;
                c = t > {1'b0, m};
                wr = 1;
            end
            CMD_SUB:
            begin
                r = (ds - ss) & m;
                v = ((ss ^ ds) & sb) != 0 && ((ss ^ r) & sb) == 0;
                c = ds < ss;
                wr = 1;
            end
            CMD_CLR: begin r = 0; v = 0; c = 0; wr = 1; end
            CMD_COM: begin r = ~ds & m; v = 0; c = 1; wr = 1; end
            CMD_INC: begin r = (ds + 1) & m; v = ds == sb - 1; wr = 1; end
            CMD_DEC: begin r = (ds - 1) & m; v = ds == sb; wr = 1; end
            CMD_NEG: begin r = (0 - ds) & m; v = r == sb; c = r != 0; wr = 1; end
            CMD_ADC:
            begin
                r = (ds + c) & m;
                v = c && ds == sb - 1;
                c = c && ds == m;
                wr = 1;
            end
            CMD_SBC:
            begin
                r = (ds - c) & m;
                v = c && ds == sb;
                c = c && ds == 0;
                wr = 1;
            end
            CMD_TST: begin r = ds; v = 0; c = 0; end
            CMD_ROR: begin r = (ds >> 1) | (c ? sb : 16'h0); c = ds[0]; wr = 1; end
            CMD_ROL: begin r = ((ds << 1) | c) & m; c = (ds & sb) != 0; wr = 1; end
            CMD_ASR: begin r = (ds >> 1) | (ds & sb); c = ds[0]; wr = 1; end
            CMD_ASL: begin r = (ds << 1) & m; c = (ds & sb) != 0; wr = 1; end
            CMD_SWAB:
            begin
                res = {rq.dst[7:0], rq.dst[15:8]};
                n = res[7];
                z = res[7:0] == 0;
                v = 0;
                c = 0;
                wr = 1;
            end
            CMD_MUL:
            begin
                prod = $signed(rq.dst) * $signed(rq.src);
                n = prod < 0;
                z = prod == 0;
                v = 0;
                c = prod < -32768 || prod > 32767;
                wr = 1;
                if (rq.is_odd)
                    res = prod[15:0];
                else
                begin
                    res = prod[31:16];
                    pres = prod[15:0];
                    wp = 1;
                end
            end
            CMD_DIV:
            begin
                x = rq.is_odd ? {rq.pair, rq.dst} : {rq.dst, rq.pair};
                dv = longint'($signed(x));
                dvs = longint'($signed(rq.src));
                if (rq.src == 0)
                begin
                    n = 0; z = 1; v = 1; c = 1;
                end
                else
                begin
                    q = dv / dvs;
                    rm = dv % dvs;
                    if (q < -32768 || q > 32767)
                    begin
                        n = 0; z = 0; v = 1; c = 0;
                    end
                    else
                    begin
                        n = q < 0;
                        z = q == 0;
                        v = 0;
                        c = 0;
                        if (rq.is_odd)
                        begin
                            pres = q[15:0];
                            res = rm[15:0];
                        end
                        else
                        begin
                            res = q[15:0];
                            pres = rm[15:0];
                        end
                        wr = 1;
                        wp = 1;
                    end
                end
            end
            CMD_ASH:
            begin
                x = shift_arith({16'h0, rq.dst}, 16, rq.src[5:0], c, v);
                res = x[15:0];
                n = res[15];
                z = res == 0;
                wr = 1;
            end
            CMD_ASHC:
            begin
                x = shift_arith(rq.is_odd ? {rq.dst, rq.dst} : {rq.dst, rq.pair}, 32,
                                rq.src[5:0], c, v);
                n = x[31];
                z = x == 0;
                wr = 1;
                if (rq.is_odd)
                    res = x[15:0];
                else
                begin
                    res = x[31:16];
                    pres = x[15:0];
                    wp = 1;
                end
            end
            CMD_CCLR:
            begin
                if (rq.fmask[3]) n = 0;
                if (rq.fmask[2]) z = 0;
                if (rq.fmask[1]) v = 0;
                if (rq.fmask[0]) c = 0;
            end
            CMD_CSET:
            begin
                if (rq.fmask[3]) n = 1;
                if (rq.fmask[2]) z = 1;
                if (rq.fmask[1]) v = 1;
                if (rq.fmask[0]) c = 1;
            end
            CMD_BR:
            begin
                case (rq.cond)
                    BC_AL:   bt = 1;
                    BC_EQ:   bt = z;
                    BC_NE:   bt = !z;
                    BC_MI:   bt = n;
                    BC_PL:   bt = !n;
                    BC_CS:   bt = c;
                    BC_CC:   bt = !c;
                    BC_VS:   bt = v;
                    BC_VC:   bt = !v;
                    BC_GE:   bt = n == v;
                    BC_LT:   bt = n != v;
                    BC_GT:   bt = !z && n == v;
                    BC_LE:   bt = z || n != v;
                    BC_HI:   bt = !c && !z;
                    BC_LOS:  bt = c || z;
                    default: bt = 0;
                endcase
            end
            default: ;
        endcase
        // The byte/word ALU group derives N and Z from the result; shifts take V = N ^ C.
        if (rq.cmd <= CMD_ASL)
        begin
            n = (r & sb) != 0;
            z = (r & m) == 0;
            if (rq.cmd >= CMD_ROR)
                v = n != c;
            if (wr)
            begin
                if (rq.cmd == CMD_MOV && bytef && rq.is_reg)
                    res = r[7] ? (r | 16'hff00) : r;
                else if (bytef)
                    res = (rq.dst & 16'hff00) | r;
                else
                    res = r;
            end
        end
        if (!wr) res = rq.dst;
        if (!wp) pres = rq.pair;
        model_flags = {n, z, v, c};
        o.res = res;
        o.pair_res = pres;
        o.wr_res = wr;
        o.wr_pair = wp;
        o.flags = model_flags;
        o.taken = bt;
        return o;
    endfunction

    // Sends one request, idling first at random, and records its expected result.
    task automatic send_request(input op_req_t rq);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
            @(negedge clk);
        s_tdata  = 64'(rq);
        s_tvalid = 1'b1;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        expected_results.push_back(execute_op(rq));
        request_count++;
        @(negedge clk);
        s_tvalid = 1'b0;
    endtask

    function automatic op_req_t random_request();
        op_req_t rq;
        rq = op_req_t'({$urandom, $urandom});
        rq.cmd = 5'($urandom_range(31));
        // Bias operands toward edge values so carries and overflows show up often.
        case ($urandom_range(5))
            0: rq.dst = 16'h8000;
            1: rq.dst = 16'h7fff;
            2: rq.dst = {8'($urandom), 8'h80};
            default: ;
        endcase
        case ($urandom_range(5))
            0: rq.src = 16'hffff;
            1: rq.src = 16'h0001;
            2: rq.src = 16'($urandom_range(40));
            default: ;
        endcase
        // Divide with a small high word so that many quotients fit.
        if (rq.cmd == CMD_DIV && $urandom_range(1))
            rq.dst = $urandom_range(1) ? 16'($urandom_range(7)) : 16'hfffe;
        return rq;
    endfunction

    function automatic op_req_t make_op(input cmd_t c, input logic bm, input logic [15:0] s,
                                        input logic [15:0] d, input logic [15:0] p);
        op_req_t rq;
        rq = '0;
        rq.cmd = c;
        rq.byte_op = bm;
        rq.src = s;
        rq.dst = d;
        rq.pair = p;
        return rq;
    endfunction

    // Result checker: compares each accepted result with the oldest expectation.
    always @(posedge clk)
    begin
        alu_res_t got;
        alu_res_t exp_res;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = alu_res_t'(m_tdata[38:0]);
            result_count++;
            if (expected_results.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("ERROR: unexpected result %h", got);
            end
            else
            begin
                exp_res = expected_results.pop_front();
                if (got !== exp_res)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("ERROR: result %0d: res %h/%h pair %h/%h wr %b%b/%b%b flags %h/%h br %b/%b",
                                 result_count, exp_res.res, got.res, exp_res.pair_res,
                                 got.pair_res, exp_res.wr_res, exp_res.wr_pair, got.wr_res,
                                 got.wr_pair, exp_res.flags, got.flags, exp_res.taken, got.taken);
                end
            end
        end
    end

    // Receiver ready, driven at the falling edge.
    always @(negedge clk)
    begin
        if (recv_hold)
            m_tready <= 1'b0;
        else
            m_tready <= !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
    end

    // Watchdog: counts cycles in which no request moves on either side.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WatchdogLimit)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic wait_drained();
        while (expected_results.size() != 0)
            @(negedge clk);
        repeat (40) @(negedge clk);
    endtask

    // Extremes of every ALU group operation, mov through asl, in word and byte form.
    task automatic test_alu_extremes();
        for (int c = CMD_MOV; c <= CMD_ASL; c++)
        begin
            send_request(make_op(cmd_t'(c), 1'b0, 16'h8000, 16'h7fff, 16'h0));
            send_request(make_op(cmd_t'(c), 1'b1, 16'hff80, 16'h807f, 16'hffff));
        end
    endtask

    // Multiply, divide and shift special cases, both register parities, plus swab and a byte mov to a register.
    task automatic test_long_ops();
        op_req_t rq;
        send_request(make_op(CMD_MUL, 1'b0, 16'h8000, 16'h8000, 16'h0));
        rq = make_op(CMD_MUL, 1'b0, 16'hffff, 16'h7fff, 16'h1234);
        rq.is_odd = 1;
        send_request(rq);
        send_request(make_op(CMD_DIV, 1'b0, 16'h0, 16'h1, 16'h0));
        send_request(make_op(CMD_DIV, 1'b0, 16'h1, 16'h7fff, 16'hffff));
        send_request(make_op(CMD_DIV, 1'b0, 16'hfff9, 16'hffff, 16'hffe0));
        rq = make_op(CMD_DIV, 1'b0, 16'h7, 16'h0064, 16'h0);
        rq.is_odd = 1;
        send_request(rq);
        send_request(make_op(CMD_ASH, 1'b0, 16'h001f, 16'h0001, 16'h0));
        send_request(make_op(CMD_ASH, 1'b0, 16'h0020, 16'h8000, 16'h0));
        send_request(make_op(CMD_ASH, 1'b0, 16'h0000, 16'h4000, 16'h0));
        send_request(make_op(CMD_ASHC, 1'b0, 16'h003f, 16'h8000, 16'h0001));
        rq = make_op(CMD_ASHC, 1'b0, 16'h0005, 16'h1234, 16'h0);
        rq.is_odd = 1;
        send_request(rq);
        send_request(make_op(CMD_SWAB, 1'b1, 16'h0, 16'h80ff, 16'h0));
        rq = make_op(CMD_MOV, 1'b1, 16'h0080, 16'h1234, 16'h0);
        rq.is_reg = 1;
        send_request(rq);
    endtask

    // Flag set and clear, every branch condition, and the undefined codes.
    task automatic test_flags_branches();
        op_req_t rq;
        for (int f = 0; f < 16; f += 5)
        begin
            rq = make_op(CMD_CSET, 1'b0, 16'h0, 16'h0, 16'h0);
            rq.fmask = 4'(f);
            send_request(rq);
            for (int b = 0; b < 16; b++)
            begin
                rq = make_op(CMD_BR, 1'b0, 16'h0, 16'h0, 16'h0);
                rq.cond = 4'(b);
                send_request(rq);
            end
            rq = make_op(CMD_CCLR, 1'b0, 16'h0, 16'h0, 16'h0);
            rq.fmask = 4'hf;
            send_request(rq);
        end
        for (int c = 27; c < 32; c++)
            send_request(op_req_t'({$urandom, 27'($urandom), 5'(c)}));
    endtask

    // Random requests across the idle and stall phases.
    task automatic test_random(input int count, input int snd, input int rcv);
        send_idle_pct = snd;
        recv_stall_pct = rcv;
        for (int i = 0; i < count; i++)
            send_request(random_request());
        wait_drained();
    endtask

    // The receiver holds off while the sender keeps offering requests.
    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        fork
            begin
                recv_hold = 1;
                repeat (300) @(negedge clk);
                recv_hold = 0;
            end
            for (int i = 0; i < 20; i++)
                send_request(random_request());
        join
        wait_drained();
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        recv_hold = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        model_flags = '0;
        request_count = 0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_alu_extremes();
        test_long_ops();
        test_flags_branches();
        wait_drained();
        test_random(360, 0, 0);
        test_random(360, 69, 0);
        test_random(360, 0, 69);
        test_random(360, 9, 9);
        test_backpressure();

        $display("Run covered %0d requests and %0d results: word, byte, multiply, divide,",
                 request_count, result_count);
        $display("shift, flag and branch operations under idle, stall and hold-off phases.");
        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule
